### hw/rtl/scia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scia_pkg - shared types and constants of the sorted class id allocator
// Table sizing, entry layout, status codes and the long id helper.
// ----------------------------------------------------------------------------
package scia_pkg;

  localparam int TABLE_DEPTH = 64;   // entries in the class table
  localparam int INDEX_BITS  = 16;   // width of an image counter / id

  localparam int KEY_W   = 16;
  localparam int AMT_W   = 16;
  localparam int LONG_W  = 32;
  localparam int CTR_W   = INDEX_BITS;
  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  // arithmetic width: counter plus amount never carries out of this
  localparam int WIDE_W  = INDEX_BITS + AMT_W + 1;

  localparam logic [CTR_W-1:0] CTR_MAX = {CTR_W{1'b1}};

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CTR_W-1:0] ctr;
  } entry_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    logic [LONG_W-1:0] long_id;
    logic              existed;
    status_e           status;
  } res_t;

  // (key << INDEX_BITS) + first, kept to LONG_W bits
  function automatic logic [LONG_W-1:0] make_long_id(input logic [KEY_W-1:0] key,
                                                      input logic [CTR_W-1:0] first);
    logic [63:0] w;
    w = (64'(key) << INDEX_BITS) + 64'(first);
    return w[LONG_W-1:0];
  endfunction

endpackage

### hw/rtl/scia_table_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scia_table_mem - class table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module scia_table_mem (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [scia_pkg::ADDR_W-1:0] waddr_i,
  input  scia_pkg::entry_t       wdata_i,
  input  logic [scia_pkg::ADDR_W-1:0] raddr_i,
  output scia_pkg::entry_t       rdata_o
);
  import scia_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/scia_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scia_alu - shared compare and add unit
// Key compares during search and counter growth share this one unit.
// ----------------------------------------------------------------------------
module scia_alu (
  input  logic [scia_pkg::WIDE_W-1:0] a_i,
  input  logic [scia_pkg::WIDE_W-1:0] b_i,
  output logic [scia_pkg::WIDE_W-1:0] sum_o,
  output logic                        lt_o,
  output logic                        eq_o
);
  import scia_pkg::*;

  assign sum_o = a_i + b_i;
  assign lt_o  = (a_i < b_i);
  assign eq_o  = (a_i == b_i);

endmodule

### hw/rtl/scia_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scia_ctrl - allocator sequencer
// Binary search, sorted insert by shifting, counter update, result build.
// ----------------------------------------------------------------------------
module scia_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_op_i,
  input  logic [scia_pkg::KEY_W-1:0]  in_key_i,
  input  logic [scia_pkg::AMT_W-1:0]  in_amt_i,
  output scia_pkg::res_t              res_o,
  input  logic                        res_take_i
);
  import scia_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_INS   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic             op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [AMT_W-1:0] amt_q, amt_d;
  logic [CNT_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CNT_W-1:0] pos_q, pos_d, idx_q, idx_d;
  entry_t           ent_q, ent_d;
  res_t             res_q, res_d;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wdata, rdata;

  logic [WIDE_W-1:0] alu_a, alu_b, alu_sum, inc;
  logic              alu_lt, alu_eq, ovf;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  idx_m1;
  logic [CTR_W-1:0]  first;

  scia_table_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  scia_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum),
    .lt_o  (alu_lt),
    .eq_o  (alu_eq)
  );

  function automatic logic [ADDR_W-1:0] idx_m1_of(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] t;
    t = v - CNT_W'(1);
    return t[ADDR_W-1:0];
  endfunction

  assign inc     = op_q ? WIDE_W'(1) : WIDE_W'(amt_q);
  assign ovf     = (alu_sum[WIDE_W-1:CTR_W] != '0);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign idx_m1  = idx_q - CNT_W'(1);

  // operand select for the shared unit
  always_comb begin
    case (state_q)
      S_PROBE, S_CHK: begin
        alu_a = WIDE_W'(rdata.key);
        alu_b = WIDE_W'(key_q);
      end
      S_UPD: begin
        alu_a = WIDE_W'(ent_q.ctr);
        alu_b = inc;
      end
      default: begin
        alu_a = '0;
        alu_b = inc;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    op_d    = op_q;
    key_d   = key_q;
    amt_d   = amt_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    ent_d   = ent_q;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = pos_q[ADDR_W-1:0];
    wdata   = '0;
    raddr   = '0;
    first   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_op_i;
          key_d   = in_key_i;
          amt_d   = in_amt_i;
          lo_d    = '0;
          hi_d    = used_q;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_sum[CNT_W:1];
          raddr   = mid_sum[ADDR_W:1];
          state_d = S_PROBE;
        end else begin
          pos_d   = lo_q;
          raddr   = lo_q[ADDR_W-1:0];
          state_d = S_CHK;
        end
      end
      S_PROBE: begin
        if (alu_lt) begin
          lo_d = mid_q + CNT_W'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = S_SRCH;
      end
      S_CHK: begin
        ent_d = rdata;
        if ((pos_q < used_q) && alu_eq) begin
          state_d = S_UPD;
        end else if (used_q == CNT_W'(TABLE_DEPTH)) begin
          res_d   = '{valid: 1'b1, long_id: '0, existed: 1'b0, status: ST_FULL};
          state_d = S_DONE;
        end else begin
          idx_d = used_q;
          if (used_q > pos_q) begin
            raddr   = idx_m1_of(used_q);
            state_d = S_SHIFT;
          end else begin
            state_d = S_INS;
          end
        end
      end
      S_UPD: begin
        if (ovf) begin
          res_d = '{valid: 1'b1, long_id: '0, existed: 1'b1, status: ST_OVF};
        end else begin
          we    = 1'b1;
          wdata = '{key: key_q, ctr: alu_sum[CTR_W-1:0]};
          first = op_q ? alu_sum[CTR_W-1:0] : ent_q.ctr;
          res_d = '{valid: 1'b1, long_id: make_long_id(key_q, first),
                    existed: 1'b1, status: ST_OK};
        end
        state_d = S_DONE;
      end
      S_SHIFT: begin
        // entry idx-1 moves up to idx; next read is one lower
        we    = 1'b1;
        waddr = idx_q[ADDR_W-1:0];
        wdata = rdata;
        idx_d = idx_m1;
        if (idx_m1 > pos_q) begin
          raddr = idx_m1_of(idx_m1);
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        we     = 1'b1;
        wdata  = '{key: key_q, ctr: (ovf ? CTR_MAX : alu_sum[CTR_W-1:0])};
        used_d = used_q + CNT_W'(1);
        first  = op_q ? CTR_W'(1) : '0;
        res_d  = '{valid: 1'b1, long_id: make_long_id(key_q, first),
                   existed: 1'b0, status: ST_OK};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          res_d.valid = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    key_q         <= key_d;
    amt_q         <= amt_d;
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    mid_q         <= mid_d;
    pos_q         <= pos_d;
    idx_q         <= idx_d;
    ent_q         <= ent_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign res_o      = res_q;

endmodule

### hw/rtl/sorted_class_id_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_class_id_allocator_unit - class id allocator, top level
// Sorted class table with per-class image counters, one request at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes a request: tdata = class_key, amount; tuser = opcode.
//   Opcode 0 reserves a block of ids (first id = old counter), opcode 1 takes
//   one id (counter pre-incremented). Master stream returns one result per
//   request: tdata = (class_key << 16) + first id, tuser = existed, status.
//   Processing: a binary search (read then compare per probe), a check of
//   the found entry, then either a counter update or a shift of each entry
//   above the insert point followed by the insert, and the hand-off. The
//   single read port of the table and the one shared compare/add unit keep
//   all of these steps in sequence, one after the other.
//   s_axis_tready is high only while the sequencer is idle. The result sits
//   in an output register, so the next request is taken while an earlier
//   result still waits; if that register is still full when the next result
//   is ready, the sequencer holds it and stays busy.
//   Reset empties the table (entry count to zero) and clears both valids;
//   table contents need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_class_id_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] class_key, [31:16] amount
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] first_long_id
  output logic [2:0]  m_axis_tuser    // [0] class_existed, [2:1] status
);
  import scia_pkg::*;

  res_t              res;
  logic              res_take;
  logic              out_valid_q;
  logic [LONG_W-1:0] out_id_q;
  logic              out_existed_q;
  status_e           out_status_q;

  scia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser[0]),
    .in_key_i   (s_axis_tdata[KEY_W-1:0]),
    .in_amt_i   (s_axis_tdata[KEY_W+AMT_W-1:KEY_W]),
    .res_o      (res),
    .res_take_i (res_take)
  );

  // output slot loads when empty or being drained this cycle
  assign res_take = res.valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_id_q      <= res.long_id;
      out_existed_q <= res.existed;
      out_status_q  <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_id_q;
  assign m_axis_tuser  = {out_status_q, out_existed_q};

  // busy right after taking a request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a request back to back");

  // a failed request carries no id
  a_fail_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:1] != ST_OK) |-> (m_axis_tdata == '0))
    else $error("failed request returned a nonzero id");

  // table full only for a new class
  a_full_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:1] == ST_FULL) |-> !m_axis_tuser[0])
    else $error("table full flagged for an existing class");

  // a finished result is kept while the output slot is blocked
  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && out_valid_q && !m_axis_tready |=> res.valid && $stable(res.long_id))
    else $error("pending result lost while output stalled");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the sorted class id allocator
// Streams lookup/insert requests into the unit, predicts each result from a
// local sorted-table model and compares every returned field, under several
// ready/valid idling patterns and a long output back-pressure stretch.
// ----------------------------------------------------------------------------
module testbench;
  import scia_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 100;
  localparam int PHASE_ITEMS    = 400;

  typedef enum logic {
    OP_RESERVE = 1'b0,   // block of ids, zero based
    OP_TAKE    = 1'b1    // single id, one based
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
  } alloc_req_t;

  typedef struct packed {
    logic [LONG_W-1:0] long_id;
    logic              existed;
    status_e           status;
  } alloc_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  sorted_class_id_allocator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // request streams and expected results
  alloc_req_t       req_pend_q[$];
  alloc_res_t       alloc_expect_q[$];
  alloc_req_t       drv_req;
  logic [KEY_W-1:0] issued_keys[$];

  // predicted class table
  logic [KEY_W-1:0] tab_key[TABLE_DEPTH];
  logic [CTR_W-1:0] tab_ctr[TABLE_DEPTH];
  int               tab_used = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int rx_hold_reqs   = 0;
  int rx_hold_seen   = 0;
  int rx_hold_left   = 0;
  int cycle_cnt      = 0;
  int err_cnt        = 0;
  int n_req          = 0;
  int n_res          = 0;
  int n_insert       = 0;
  int n_hit          = 0;
  int n_full         = 0;
  int n_ovf          = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t result %0d: %s", $time, n_res, msg);
    err_cnt++;
  endtask

  // lower-bound search, then hit update / sorted insert / full / overflow
  function automatic void alloc_predict(input alloc_req_t r);
    int               lo;
    int               hi;
    int               mid;
    logic [CTR_W:0]   grown;
    logic [CTR_W-1:0] old_ctr;
    logic [CTR_W-1:0] first_id;
    alloc_res_t       res;
    res.long_id = '0;
    res.existed = 1'b0;
    res.status  = ST_OK;
    first_id    = '0;
    lo = 0;
    hi = tab_used;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tab_key[mid] < r.key) lo = mid + 1;
      else hi = mid;
    end
    if (lo < tab_used && tab_key[lo] == r.key) begin
      res.existed = 1'b1;
      old_ctr = tab_ctr[lo];
      if (r.op == OP_RESERVE) grown = (CTR_W+1)'(old_ctr) + (CTR_W+1)'(r.amount);
      else grown = (CTR_W+1)'(old_ctr) + (CTR_W+1)'(1);
      if (grown > (CTR_W+1)'(CTR_MAX)) begin
        res.status = ST_OVF;
        n_ovf++;
      end else begin
        tab_ctr[lo] = grown[CTR_W-1:0];
        first_id = (r.op == OP_RESERVE) ? old_ctr : grown[CTR_W-1:0];
        n_hit++;
      end
    end else if (tab_used >= TABLE_DEPTH) begin
      res.status = ST_FULL;
      n_full++;
    end else begin
      for (int i = tab_used; i > lo; i--) begin
        tab_key[i] = tab_key[i-1];
        tab_ctr[i] = tab_ctr[i-1];
      end
      tab_key[lo] = r.key;
      tab_ctr[lo] = (r.op == OP_RESERVE) ? CTR_W'(r.amount) : CTR_W'(1);
      tab_used++;
      first_id = (r.op == OP_RESERVE) ? CTR_W'(0) : CTR_W'(1);
      n_insert++;
    end
    if (res.status == ST_OK)
      res.long_id = (LONG_W'(r.key) << INDEX_BITS) + LONG_W'(first_id);
    alloc_expect_q.insert(alloc_expect_q.size(), res);
  endfunction

  function automatic void note_key(input logic [KEY_W-1:0] k);
    foreach (issued_keys[i])
      if (issued_keys[i] == k) return;
    issued_keys.insert(issued_keys.size(), k);
  endfunction

  function automatic void push_req(input op_e op, input logic [KEY_W-1:0] k,
                                   input logic [AMT_W-1:0] amt);
    alloc_req_t r;
    r.op     = op;
    r.key    = k;
    r.amount = amt;
    note_key(k);
    req_pend_q.insert(req_pend_q.size(), r);
  endfunction

  // mostly known classes; fresh keys more often until well past TABLE_DEPTH keys were issued
  function automatic void push_random_req();
    int               sel;
    int               new_pct;
    logic [KEY_W-1:0] k;
    logic [AMT_W-1:0] amt;
    new_pct = (issued_keys.size() < TABLE_DEPTH + 8) ? 25 : 5;
    if (issued_keys.size() == 0 || $urandom_range(0, 99) < new_pct)
      k = KEY_W'($urandom_range(0, 65535));
    else
      k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
    sel = $urandom_range(0, 99);
    if (sel < 60) amt = AMT_W'($urandom_range(0, 15));
    else if (sel < 85) amt = AMT_W'($urandom_range(0, 4095));
    else amt = AMT_W'($urandom_range(0, 65535));
    push_req(op_e'($urandom_range(0, 1)), k, amt);
  endfunction

  task automatic wait_drained();
    while (req_pend_q.size() != 0 || s_valid || alloc_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready) begin
        alloc_predict(drv_req);
        n_req++;
      end
      if (!s_valid || s_axis_tready) begin
        if (req_pend_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_req = req_pend_q.pop_front();
          s_valid <= 1'b1;
          s_tdata <= {drv_req.amount, drv_req.key};
          s_tuser <= drv_req.op;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off, counted here
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_seen != rx_hold_reqs) begin
      rx_hold_left <= RX_HOLD_CYCLES;
      rx_hold_seen <= rx_hold_reqs;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    alloc_res_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_ready) begin
        if (alloc_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata=%h tuser=%b",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = alloc_expect_q.pop_front();
          if (m_axis_tdata !== want.long_id)
            report_mismatch($sformatf("long id %h, want %h", m_axis_tdata, want.long_id));
          if (m_axis_tuser[0] !== want.existed)
            report_mismatch($sformatf("existed %b, want %b", m_axis_tuser[0], want.existed));
          if (m_axis_tuser[2:1] !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser[2:1],
                                      want.status));
        end
        n_res++;
      end
      m_ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_cnt);
      $display("sorted_class_id_allocator_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: head/tail/middle inserts, zero amount, counter limits
    push_req(OP_TAKE,    16'h8000, 16'h0000);  // new class, id 1
    push_req(OP_RESERVE, 16'h8000, 16'h0000);  // zero amount on a hit
    push_req(OP_RESERVE, 16'h0000, 16'hFFFF);  // head insert, counter at max
    push_req(OP_TAKE,    16'h0000, 16'h0000);  // single id overflows
    push_req(OP_RESERVE, 16'h0000, 16'h0000);  // zero amount at max is fine
    push_req(OP_RESERVE, 16'h0000, 16'h0001);  // block overflows
    push_req(OP_RESERVE, 16'hFFFF, 16'h1234);  // tail insert
    push_req(OP_RESERVE, 16'hFFFF, 16'hEDCB);  // lands exactly on max
    push_req(OP_TAKE,    16'hFFFF, 16'hFFFF);  // overflow, amount ignored
    push_req(OP_RESERVE, 16'h0001, 16'h0005);  // key one, insert after head
    push_req(OP_TAKE,    16'h0001, 16'h0000);
    push_req(OP_RESERVE, 16'h4000, 16'h0000);  // new class with zero amount
    push_req(OP_TAKE,    16'h4000, 16'h0000);
    push_req(OP_TAKE,    16'h7FFF, 16'h0000);
    push_req(OP_TAKE,    16'h8001, 16'h0000);
    push_req(OP_RESERVE, 16'hAAAA, 16'hAAAA);
    push_req(OP_RESERVE, 16'h5555, 16'h5555);
    push_req(OP_RESERVE, 16'h5555, 16'h5555);
    push_req(OP_RESERVE, 16'h5555, 16'h5556);  // one past max
    wait_drained();

    // back-pressure: output held while requests keep coming
    rx_hold_reqs <= rx_hold_reqs + 1;
    repeat (30) push_random_req();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 86; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 86; end
        default: begin send_idle_pct <= 36; recv_stall_pct <= 36; end
      endcase
      repeat (PHASE_ITEMS / 2) push_random_req();
      wait_drained();  // sender pause until every result is back
      repeat (PHASE_ITEMS / 2) push_random_req();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d requests: %0d inserts, %0d hits, %0d table full, %0d overflow",
             n_req, n_insert, n_hit, n_full, n_ovf);
    $display("Table held %0d classes at the end; %0d mismatches", tab_used, err_cnt);
    if (err_cnt == 0) begin
      $display("sorted_class_id_allocator_unit verification clean");
    end else begin
      $display("sorted_class_id_allocator_unit verification failed");
    end
    $finish;
  end

endmodule
